>>> rtl/core/integer_set_table_defines.svh
// assertion macros shared by the checker of integer_set_table
// each macro samples on the rising edge of clk and is disabled while arst_n is low
`ifndef INTEGER_SET_TABLE_DEFINES_SVH
`define INTEGER_SET_TABLE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define IST_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ist_pkg.sv
`default_nettype none

package ist_pkg;

	// operation codes
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NEG  = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam int KEY_W   = 31;
	localparam int COUNT_W = 7;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [COUNT_W-1:0] count;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       scan;
		logic       add_wr;
		logic       move_rd;
		logic       move_wr;
		logic       set_status;
		logic [1:0] status_code;
	} ist_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       neg;
		logic       scan_done;
		logic       found;
		logic       full;
		logic [1:0] kind;
	} ist_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/ist_datapath.sv
`default_nettype none

module ist_datapath
	import ist_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire req_t     req,
	input  wire ist_cmd_t cmd,
	output ist_sts_t      sts,
	output rsp_t          rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [KEY_W-1:0] mem [CAPACITY];
	logic [KEY_W-1:0] rd_data_q;
	logic [KEY_W-1:0] key_q;
	logic             neg_q;
	logic [1:0]       kind_q;
	logic [CW-1:0]    held_q;
	logic [CW-1:0]    idx_q;
	logic [AW-1:0]    cmp_idx_q;
	logic             cmp_vld_q;
	logic             found_q;
	logic [AW-1:0]    pos_q;
	logic [1:0]       status_q;

	logic [CW-1:0]    held_last;
	logic             scan_issue;
	logic             scan_more;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [KEY_W-1:0] wr_data;

	assign held_last  = held_q - CW'(1);
	assign scan_more  = (idx_q < held_q);
	assign scan_issue = cmd.scan && scan_more;

	// one read port shared by the scan and the last-entry fetch of a remove
	assign rd_addr = cmd.move_rd ? held_last[AW-1:0] : idx_q[AW-1:0];

	// one write port: append on add, fill the freed slot on remove
	assign wr_en   = cmd.add_wr | cmd.move_wr;
	assign wr_addr = cmd.add_wr ? held_q[AW-1:0] : pos_q;
	assign wr_data = cmd.add_wr ? key_q : rd_data_q;

	// entry storage, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// operation capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q  <= req.value[KEY_W-1:0];
			neg_q  <= req.value[31];
			kind_q <= req.kind;
		end
	end

	// scan pointer, compare stage and element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q     <= '0;
				cmp_vld_q <= 1'b0;
				found_q   <= 1'b0;
			end else begin
				cmp_vld_q <= scan_issue;
				if (scan_issue) begin
					idx_q <= idx_q + CW'(1);
				end
				if (cmp_vld_q && (rd_data_q == key_q)) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.add_wr) begin
				held_q <= held_q + CW'(1);
			end else if (cmd.move_rd) begin
				held_q <= held_last;
			end
		end
	end

	// match position and result status
	always_ff @(posedge clk) begin
		if (scan_issue) begin
			cmp_idx_q <= idx_q[AW-1:0];
		end
		if (cmp_vld_q && !found_q && (rd_data_q == key_q)) begin
			pos_q <= cmp_idx_q;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_code;
		end
	end

	assign sts.neg       = neg_q;
	assign sts.scan_done = found_q || (!cmp_vld_q && !scan_more);
	assign sts.found     = found_q;
	assign sts.full      = (held_q >= CW'(CAPACITY));
	assign sts.kind      = kind_q;

	assign rsp.status = status_q;
	assign rsp.count  = COUNT_W'(held_q);

endmodule

`default_nettype wire

>>> rtl/core/ist_ctrl.sv
`default_nettype none

module ist_ctrl
	import ist_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire ist_sts_t sts,
	output ist_cmd_t      cmd,
	output logic          busy,
	output logic          done
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_MOVE = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.neg) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_NEG;
					state_nxt       = S_RESP;
				end else if (sts.scan_done) begin
					cmd.set_status = 1'b1;
					state_nxt      = S_RESP;
					unique case (sts.kind)
						KIND_ADD: begin
							if (sts.found) begin
								cmd.status_code = ST_MISS;
							end else if (sts.full) begin
								cmd.status_code = ST_FULL;
							end else begin
								cmd.add_wr      = 1'b1;
								cmd.status_code = ST_OK;
							end
						end
						KIND_REMOVE: begin
							if (sts.found) begin
								cmd.set_status = 1'b0;
								cmd.move_rd    = 1'b1;
								state_nxt      = S_MOVE;
							end else begin
								cmd.status_code = ST_MISS;
							end
						end
						default: begin
							cmd.status_code = sts.found ? ST_OK : ST_MISS;
						end
					endcase
				end
			end
			S_MOVE: begin
				cmd.move_wr     = 1'b1;
				cmd.set_status  = 1'b1;
				cmd.status_code = ST_OK;
				state_nxt       = S_RESP;
			end
			S_RESP: begin
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_RESP);

endmodule

`default_nettype wire

>>> rtl/core/integer_set_table.sv
// integer_set_table: bounded set of non-negative 31-bit keys
//
// input transfer: req (kind, value) is taken at a rising edge with start high and busy low.
// kind selects add, remove or membership query; kind code 3 acts as a query.
// output transfer: done pulses for one cycle with rsp (status, count); it cannot be held off.
// count is the number of keys held after the operation, modulo 128.
//
// with n keys held, a negative key, or any operation on an empty table, is answered
// without scanning. otherwise the keys are scanned one per cycle through the one read
// port of the entry memory: a hit ends the scan at its slot, a miss reads all n keys,
// and a remove that hits then moves the last key into the freed slot.
// busy drops after the result cycle, so the block takes no new transfer while one is
// in flight.
//
// reset: arst_n clears the count and the controller; the entry memory is not
// cleared since only data read from slots below the count is ever used.
`default_nettype none

module integer_set_table
	import ist_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	ist_cmd_t cmd;
	ist_sts_t sts;

	// sequencing
	ist_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// entry storage, scan compare and count
	ist_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

>>> rtl/core/ist_checker.sv
`default_nettype none

`include "integer_set_table_defines.svh"

module ist_checker
	import ist_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t rsp
);

	// an accepted transfer must raise busy, which the block holds until its result
	`IST_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")

	// a result only appears while an operation is in flight
	`IST_ASSERT_SAME(a_done_busy, done, busy, "result strobe while idle")

	// the result strobe is a single cycle and frees the block
	`IST_ASSERT_NEXT(a_done_frees, done, !done && !busy, "result strobe not followed by idle")

	// a full rejection reports the table at capacity
	`IST_ASSERT_SAME(a_full_count, done && (rsp.status == ST_FULL), rsp.count == COUNT_W'(CAPACITY), "full status with count below capacity")

endmodule

bind integer_set_table ist_checker #(
	.CAPACITY (CAPACITY)
) u_ist_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire
